// ===== rtl/yfbfr_lifting_color_transform_core_macros.svh =====
// Assertion macros for the YFbFr lifting color transform core.
// Used by the port checker; expects i_clk and i_rst_n in scope.
`ifndef YFBFR_LIFTING_COLOR_TRANSFORM_CORE_MACROS_SVH
`define YFBFR_LIFTING_COLOR_TRANSFORM_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define YFBFR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("yfbfr: implication check failed");

// Next-cycle implication, disabled during reset.
`define YFBFR_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("yfbfr: next-cycle check failed");

`endif

// ===== rtl/yfbfr_pkg.sv =====
// Shared types and constants for the YFbFr lifting color transform core.
// No dependencies; used by every RTL module of the block but the checker yfbfr_chk.
package yfbfr_pkg;

    // Internal signed width: covers inverse offsets up to 2^30 times 23.
    localparam int DW = 48;

    typedef logic signed [DW-1:0] t_sw;

    typedef enum logic {
        DIR_FWD = 1'b0,
        DIR_INV = 1'b1
    } t_dir;

    typedef enum logic [1:0] {
        VAR_V1 = 2'd0,
        VAR_V2 = 2'd1,
        VAR_V3 = 2'd2,
        VAR_V4 = 2'd3
    } t_variant;

    // Configuration register indexes.
    localparam logic [2:0] CFG_DIRECTION    = 3'd0;
    localparam logic [2:0] CFG_VARIANT      = 3'd1;
    localparam logic [2:0] CFG_CHROMA_DEPTH = 3'd2;
    localparam logic [2:0] CFG_FIRST_MIN    = 3'd3;
    localparam logic [2:0] CFG_FIRST_MAX    = 3'd4;
    localparam logic [2:0] CFG_OTHER_MIN    = 3'd5;
    localparam logic [2:0] CFG_OTHER_MAX    = 3'd6;

    // Lifting weight numerators.
    localparam t_sw LIFT_K3  = t_sw'(3);
    localparam t_sw LIFT_K5  = t_sw'(5);
    localparam t_sw LIFT_K23 = t_sw'(23);
    localparam t_sw LIFT_K1  = t_sw'(1);

    typedef struct packed {
        t_dir        direction;
        t_variant    variant;
        logic [4:0]  chroma_depth;
        logic [15:0] first_min;
        logic [15:0] first_max;
        logic [15:0] other_min;
        logic [15:0] other_max;
    } t_cfg;

    // Unclipped word handed from the lifting pipe to the clip stage.
    typedef struct packed {
        logic vld;
        t_sw  x0;
        t_sw  x1;
        t_sw  x2;
    } t_pre;

endpackage

// ===== rtl/yfbfr_lifting_color_transform_core.sv =====
// YFbFr lifting color transform core: one pixel per clock, RGB <-> YFbFr.
// Each pixel passes through the four lifting registers and the clip register to its
// result word; o_res_strobe rises with that word and holds for one cycle.
// Throughput: one word per cycle; busy never rises, the receiver cannot stall.
// Reset (i_rst_n low, synchronous) flushes the pipe and loads register defaults.
// Depends on yfbfr_pkg, yfbfr_cfg, yfbfr_lift and yfbfr_clip.
module yfbfr_lifting_color_transform_core #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Pixel command channel
    input  logic        start,
    output logic        busy,
    input  logic [15:0] i_comp_zero,
    input  logic [15:0] i_comp_one,
    input  logic [15:0] i_comp_two,
    // Result channel: one word per strobe, cannot be held off
    output logic        o_res_strobe,
    output logic [15:0] o_res_zero,
    output logic [15:0] o_res_one,
    output logic [15:0] o_res_two,
    // Configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    yfbfr_pkg::t_cfg cfg;
    yfbfr_pkg::t_pre pre;
    logic            lift_active;
    logic            accept;

    // Every cycle can take a new pixel: no internal hazard, no back-pressure.
    // The five register stages (four lifting, one clip) set the latency only;
    // each stage advances every cycle.
    assign busy   = 1'b0;
    assign accept = start & ~busy;

    // Hold off config writes while a word is offered or still in flight, so
    // the settings each word sees stay fixed from entry to strobe.
    assign o_cfg_ready = ~(start | lift_active | o_res_strobe);

    yfbfr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_valid & o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    // Stages 1-4: differences, two lifting steps, chroma offset/doubling.
    yfbfr_lift #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lift (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_vld    (accept),
        .i_c0     (i_comp_zero),
        .i_c1     (i_comp_one),
        .i_c2     (i_comp_two),
        .o_pre    (pre),
        .o_active (lift_active)
    );

    // Stage 5: clip each component and register the result word.
    yfbfr_clip #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_clip (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_pre      (pre),
        .o_strobe   (o_res_strobe),
        .o_res_zero (o_res_zero),
        .o_res_one  (o_res_one),
        .o_res_two  (o_res_two)
    );

endmodule

// ===== rtl/yfbfr_cfg.sv =====
// Configuration register file of the YFbFr core.
// Depends on yfbfr_pkg for the register indexes and the t_cfg struct.
module yfbfr_cfg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_we,
    input  logic [2:0]          i_index,
    input  logic [15:0]         i_data,
    output yfbfr_pkg::t_cfg     o_cfg
);

    yfbfr_pkg::t_cfg r_cfg;
    yfbfr_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_we) begin
            case (i_index)
                yfbfr_pkg::CFG_DIRECTION:    n_cfg.direction = yfbfr_pkg::t_dir'(i_data[0]);
                yfbfr_pkg::CFG_VARIANT:      n_cfg.variant = yfbfr_pkg::t_variant'(i_data[1:0]);
                yfbfr_pkg::CFG_CHROMA_DEPTH: n_cfg.chroma_depth = i_data[4:0];
                yfbfr_pkg::CFG_FIRST_MIN:    n_cfg.first_min = i_data;
                yfbfr_pkg::CFG_FIRST_MAX:    n_cfg.first_max = i_data;
                yfbfr_pkg::CFG_OTHER_MIN:    n_cfg.other_min = i_data;
                yfbfr_pkg::CFG_OTHER_MAX:    n_cfg.other_max = i_data;
                default:                     n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.direction    <= yfbfr_pkg::DIR_FWD;
            r_cfg.variant      <= yfbfr_pkg::VAR_V1;
            r_cfg.chroma_depth <= 5'd10;
            r_cfg.first_min    <= 16'd0;
            r_cfg.first_max    <= 16'd1023;
            r_cfg.other_min    <= 16'd0;
            r_cfg.other_max    <= 16'd1023;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/yfbfr_lift.sv =====
// Four-stage lifting pipeline of the YFbFr core (forward and inverse).
// Depends on yfbfr_pkg for the signed word, config and handoff types.
module yfbfr_lift #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  yfbfr_pkg::t_cfg     i_cfg,
    input  logic                i_vld,
    input  logic [15:0]         i_c0,
    input  logic [15:0]         i_c1,
    input  logic [15:0]         i_c2,
    output yfbfr_pkg::t_pre     o_pre,
    output logic                o_active
);

    localparam logic [15:0] SMASK = 16'((32'd1 << SAMPLE_BITS) - 32'd1);

    function automatic yfbfr_pkg::t_sw ext16(input logic [15:0] x);
        return yfbfr_pkg::t_sw'({{(yfbfr_pkg::DW-16){1'b0}}, x});
    endfunction

    function automatic yfbfr_pkg::t_sw lift1(input yfbfr_pkg::t_sw v,
                                             input yfbfr_pkg::t_variant vsel);
        if (vsel == yfbfr_pkg::VAR_V4)
            return (v * yfbfr_pkg::LIFT_K3) >>> 2;
        return v >>> 1;
    endfunction

    function automatic yfbfr_pkg::t_sw lift2(input yfbfr_pkg::t_sw u,
                                             input yfbfr_pkg::t_variant vsel);
        yfbfr_pkg::t_sw res;
        case (vsel)
            yfbfr_pkg::VAR_V1: res = (u * yfbfr_pkg::LIFT_K3) >>> 3;
            yfbfr_pkg::VAR_V2: res = (u * yfbfr_pkg::LIFT_K5) >>> 3;
            default:           res = (u * yfbfr_pkg::LIFT_K23) >>> 5;
        endcase
        return res;
    endfunction

    logic fwd;
    assign fwd = (i_cfg.direction == yfbfr_pkg::DIR_FWD);

    // Stage 1: masked inputs, chroma differences
    logic r1_vld, n1_vld;
    yfbfr_pkg::t_sw r1_c0, r1_c1, r1_c2, r1_v, r1_u;
    yfbfr_pkg::t_sw n1_c0, n1_c1, n1_c2, n1_v, n1_u, off_inv;

    always_comb begin
        n1_vld  = i_vld;
        n1_c0   = ext16(i_c0 & SMASK);
        n1_c1   = ext16(i_c1 & SMASK);
        n1_c2   = ext16(i_c2 & SMASK);
        off_inv = (i_cfg.chroma_depth == 5'd0) ? '0
                : (yfbfr_pkg::LIFT_K1 <<< (i_cfg.chroma_depth - 5'd1));
        if (fwd) begin
            n1_v = n1_c0 - n1_c2;
            n1_u = '0;
        end else begin
            n1_v = (n1_c1 - off_inv) <<< 1;
            n1_u = (n1_c2 - off_inv) <<< 1;
        end
    end

    // Stage 2: first lifting step (a forward, b inverse)
    logic r2_vld, n2_vld;
    yfbfr_pkg::t_sw r2_v, r2_u, r2_c1, r2_p;
    yfbfr_pkg::t_sw n2_p;

    always_comb begin
        n2_vld = r1_vld;
        n2_p   = fwd ? (r1_c2 + lift1(r1_v, i_cfg.variant))
                     : (r1_c0 - lift2(r1_u, i_cfg.variant));
    end

    // Stage 3: u forward; g and B inverse
    logic r3_vld, n3_vld;
    yfbfr_pkg::t_sw r3_v, r3_p, r3_q;
    yfbfr_pkg::t_sw n3_p, n3_q;

    always_comb begin
        n3_vld = r2_vld;
        if (fwd) begin
            n3_p = r2_p;
            n3_q = r2_c1 - r2_p;
        end else begin
            n3_p = r2_p - lift1(r2_v, i_cfg.variant);
            n3_q = r2_u + r2_p;
        end
    end

    // Stage 4: Y and offset chroma forward; R inverse
    yfbfr_pkg::t_pre r4_pre, n4_pre;
    yfbfr_pkg::t_sw  off_fwd;

    always_comb begin
        off_fwd    = ext16(i_cfg.other_max);
        n4_pre.vld = r3_vld;
        if (fwd) begin
            n4_pre.x0 = r3_p + lift2(r3_q, i_cfg.variant);
            n4_pre.x1 = (r3_v + off_fwd) >>> 1;
            n4_pre.x2 = (r3_q + off_fwd) >>> 1;
        end else begin
            n4_pre.x0 = r3_v + r3_p;
            n4_pre.x1 = r3_q;
            n4_pre.x2 = r3_p;
        end
    end

    // Valid bits: cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld     <= 1'b0;
            r2_vld     <= 1'b0;
            r3_vld     <= 1'b0;
            r4_pre.vld <= 1'b0;
        end else begin
            r1_vld     <= n1_vld;
            r2_vld     <= n2_vld;
            r3_vld     <= n3_vld;
            r4_pre.vld <= n4_pre.vld;
        end
    end

    // Payload: no reset
    always_ff @(posedge i_clk) begin
        r1_c0     <= n1_c0;
        r1_c1     <= n1_c1;
        r1_c2     <= n1_c2;
        r1_v      <= n1_v;
        r1_u      <= n1_u;
        r2_v      <= r1_v;
        r2_u      <= r1_u;
        r2_c1     <= r1_c1;
        r2_p      <= n2_p;
        r3_v      <= r2_v;
        r3_p      <= n3_p;
        r3_q      <= n3_q;
        r4_pre.x0 <= n4_pre.x0;
        r4_pre.x1 <= n4_pre.x1;
        r4_pre.x2 <= n4_pre.x2;
    end

    assign o_pre    = r4_pre;
    assign o_active = r1_vld | r2_vld | r3_vld | r4_pre.vld;

endmodule

// ===== rtl/yfbfr_clip.sv =====
// Clip and output register stage of the YFbFr core.
// Depends on yfbfr_pkg for the config and handoff types.
module yfbfr_clip #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  yfbfr_pkg::t_cfg     i_cfg,
    input  yfbfr_pkg::t_pre     i_pre,
    output logic                o_strobe,
    output logic [15:0]         o_res_zero,
    output logic [15:0]         o_res_one,
    output logic [15:0]         o_res_two
);

    localparam logic [15:0] SMASK = 16'((32'd1 << SAMPLE_BITS) - 32'd1);

    function automatic yfbfr_pkg::t_sw ext16(input logic [15:0] x);
        return yfbfr_pkg::t_sw'({{(yfbfr_pkg::DW-16){1'b0}}, x});
    endfunction

    // Raise to min, then lower to max: max wins when the bounds cross.
    function automatic logic [15:0] clip(input yfbfr_pkg::t_sw x,
                                         input logic [15:0] lo,
                                         input logic [15:0] hi);
        yfbfr_pkg::t_sw t;
        t = x;
        if (t < ext16(lo))
            t = ext16(lo);
        if (t > ext16(hi))
            t = ext16(hi);
        if (t < 0)
            t = '0;
        return t[15:0];
    endfunction

    logic [15:0] first_hi, other_hi;
    logic        r_strobe;
    logic [15:0] r_res_zero, r_res_one, r_res_two;
    logic [15:0] n_res_zero, n_res_one, n_res_two;

    always_comb begin
        first_hi   = (i_cfg.first_max > SMASK) ? SMASK : i_cfg.first_max;
        other_hi   = (i_cfg.other_max > SMASK) ? SMASK : i_cfg.other_max;
        n_res_zero = clip(i_pre.x0, i_cfg.first_min, first_hi);
        n_res_one  = clip(i_pre.x1, i_cfg.other_min, other_hi);
        n_res_two  = clip(i_pre.x2, i_cfg.other_min, other_hi);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_pre.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res_zero <= n_res_zero;
        r_res_one  <= n_res_one;
        r_res_two  <= n_res_two;
    end

    assign o_strobe   = r_strobe;
    assign o_res_zero = r_res_zero;
    assign o_res_one  = r_res_one;
    assign o_res_two  = r_res_two;

endmodule

// ===== rtl/yfbfr_chk.sv =====
// Port-level checker for the YFbFr core, bound to the top level.
// Depends on yfbfr_lifting_color_transform_core_macros.svh.
`include "yfbfr_lifting_color_transform_core_macros.svh"

module yfbfr_chk (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic        o_res_strobe,
    input  logic        o_cfg_ready,
    input  logic        i_cfg_valid
);

    // Every accepted word strobes out after the four lifting registers and the clip register.
    `YFBFR_ASSERT_IMP(a_latency, start && !busy, ##5 o_res_strobe)

    // No strobe without an accepted word behind it in the lifting and clip registers.
    `YFBFR_ASSERT_IMP(a_no_orphan, o_res_strobe, $past(start && !busy, 5))

    // Config writes are held off while a word is in flight.
    `YFBFR_ASSERT_NXT(a_cfg_hold, start && !busy, !o_cfg_ready)

    // A config write never lands on the edge that takes a pixel.
    `YFBFR_ASSERT_IMP(a_cfg_apart, i_cfg_valid && o_cfg_ready, !(start && !busy))

    // Pipe is always open to new pixels.
    `YFBFR_ASSERT_IMP(a_never_busy, 1'b1, !busy)

endmodule

bind yfbfr_lifting_color_transform_core yfbfr_chk u_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_res_strobe (o_res_strobe),
    .o_cfg_ready  (o_cfg_ready),
    .i_cfg_valid  (i_cfg_valid)
);

// ===== verif/yfbfr_pixel_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the YFbFr lifting color transform core: predicts each pixel word.
// Depends on yfbfr_pkg; watches the command, result and configuration channels.
module yfbfr_pixel_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic [15:0] i_comp_zero,
    input  logic [15:0] i_comp_one,
    input  logic [15:0] i_comp_two,
    input  logic        i_res_strobe,
    input  logic [15:0] i_res_zero,
    input  logic [15:0] i_res_one,
    input  logic [15:0] i_res_two,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output int          o_mismatches,
    output int          o_pending
);

    typedef struct packed {
        logic [15:0] zero;
        logic [15:0] one;
        logic [15:0] two;
    } t_pixel;

    localparam yfbfr_pkg::t_cfg CFG_AT_RESET = '{
        direction: yfbfr_pkg::DIR_FWD, variant: yfbfr_pkg::VAR_V1, chroma_depth: 5'd10,
        first_min: 16'd0, first_max: 16'd1023, other_min: 16'd0, other_max: 16'd1023
    };
    localparam int PRINT_CAP = 100;

    yfbfr_pkg::t_cfg cfg_shadow = CFG_AT_RESET;
    t_pixel          pixel_q[$];
    t_pixel          wanted;
    int              fail_count = 0;
    int              pending_words = 0;

    assign o_mismatches = fail_count;
    assign o_pending    = pending_words;

    task automatic report(input string line);
        if (fail_count < PRINT_CAP) begin
            $display("%0t checker: %s", $time, line);
        end
        fail_count++;
    endtask

    // First lifting weight: 1/2, or 3/4 for V4. >>> on longint rounds toward minus infinity.
    function automatic longint lift_first(input longint x, input yfbfr_pkg::t_variant vsel);
        return (vsel == yfbfr_pkg::VAR_V4) ? (3 * x) >>> 2 : x >>> 1;
    endfunction

    // Second lifting weight: 3/8 for V1, 5/8 for V2, 23/32 for V3 and V4.
    function automatic longint lift_second(input longint x, input yfbfr_pkg::t_variant vsel);
        case (vsel)
            yfbfr_pkg::VAR_V1: return (3 * x) >>> 3;
            yfbfr_pkg::VAR_V2: return (5 * x) >>> 3;
            default:           return (23 * x) >>> 5;
        endcase
    endfunction

    // Raise to the minimum, then lower to the maximum, so the maximum wins.
    function automatic logic [15:0] clamp_sample(input longint x, input logic [15:0] lo,
                                                 input logic [15:0] hi);
        longint top_val;
        longint y;
        top_val = longint'(hi);
        y       = x;
        if (top_val > (longint'(1) << SAMPLE_BITS) - 1) begin
            top_val = (longint'(1) << SAMPLE_BITS) - 1;
        end
        if (y < longint'(lo)) y = longint'(lo);
        if (y > top_val) y = top_val;
        if (y < 0) y = 0;
        return y[15:0];
    endfunction

    function automatic t_pixel predict_pixel(input yfbfr_pkg::t_cfg c, input logic [15:0] in0,
                                             input logic [15:0] in1, input logic [15:0] in2);
        longint mask, c0, c1, c2, v, u, a, y, b, bb, g, r, ofs;
        t_pixel p;
        mask = (longint'(1) << SAMPLE_BITS) - 1;
        c0   = longint'(in0) & mask;
        c1   = longint'(in1) & mask;
        c2   = longint'(in2) & mask;
        if (c.direction == yfbfr_pkg::DIR_FWD) begin
            v      = c0 - c2;
            a      = c2 + lift_first(v, c.variant);
            u      = c1 - a;
            y      = a + lift_second(u, c.variant);
            ofs    = longint'(c.other_max);
            p.zero = clamp_sample(y, c.first_min, c.first_max);
            p.one  = clamp_sample((v + ofs) >>> 1, c.other_min, c.other_max);
            p.two  = clamp_sample((u + ofs) >>> 1, c.other_min, c.other_max);
        end else begin
            ofs    = (c.chroma_depth == 5'd0) ? 0 : longint'(1) << (c.chroma_depth - 1);
            v      = 2 * (c1 - ofs);
            u      = 2 * (c2 - ofs);
            b      = c0 - lift_second(u, c.variant);
            g      = u + b;
            bb     = b - lift_first(v, c.variant);
            r      = v + bb;
            p.zero = clamp_sample(r, c.first_min, c.first_max);
            p.one  = clamp_sample(g, c.other_min, c.other_max);
            p.two  = clamp_sample(bb, c.other_min, c.other_max);
        end
        return p;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_shadow = CFG_AT_RESET;
            pixel_q.delete();
        end else begin
            if (i_res_strobe) begin
                if (pixel_q.size() == 0) begin
                    report($sformatf("result word %h %h %h with nothing pending",
                                     i_res_zero, i_res_one, i_res_two));
                end else begin
                    wanted = pixel_q.pop_front();
                    if (i_res_zero !== wanted.zero)
                        report($sformatf("res_zero got %h want %h", i_res_zero, wanted.zero));
                    if (i_res_one !== wanted.one)
                        report($sformatf("res_one got %h want %h", i_res_one, wanted.one));
                    if (i_res_two !== wanted.two)
                        report($sformatf("res_two got %h want %h", i_res_two, wanted.two));
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    yfbfr_pkg::CFG_DIRECTION:
                        cfg_shadow.direction = yfbfr_pkg::t_dir'(i_cfg_data[0]);
                    yfbfr_pkg::CFG_VARIANT:
                        cfg_shadow.variant = yfbfr_pkg::t_variant'(i_cfg_data[1:0]);
                    yfbfr_pkg::CFG_CHROMA_DEPTH: cfg_shadow.chroma_depth = i_cfg_data[4:0];
                    yfbfr_pkg::CFG_FIRST_MIN:    cfg_shadow.first_min    = i_cfg_data;
                    yfbfr_pkg::CFG_FIRST_MAX:    cfg_shadow.first_max    = i_cfg_data;
                    yfbfr_pkg::CFG_OTHER_MIN:    cfg_shadow.other_min    = i_cfg_data;
                    yfbfr_pkg::CFG_OTHER_MAX:    cfg_shadow.other_max    = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_start && !i_busy) begin
                pixel_q.push_back(predict_pixel(cfg_shadow, i_comp_zero, i_comp_one,
                                                i_comp_two));
            end
        end
        pending_words = pixel_q.size();
    end

endmodule

// ===== verif/tb_yfbfr_lifting_color_transform_core.sv =====
`timescale 1ns / 1ps
// Testbench top for the YFbFr lifting color transform core: drives pixel words and settings.
// Depends on yfbfr_pkg, the core and yfbfr_pixel_checker, which predicts and compares.
module tb_yfbfr_lifting_color_transform_core;

    localparam int SAMPLE_BITS   = 16;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_PHASES = 16;
    localparam int PHASE_WORDS   = 25;
    // Five register stages from the start edge to the strobe; wait a little longer.
    localparam int DRAIN_CYCLES  = 8;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [15:0] i_comp_zero = 16'd0;
    logic [15:0] i_comp_one = 16'd0;
    logic [15:0] i_comp_two = 16'd0;
    logic        o_res_strobe;
    logic [15:0] o_res_zero;
    logic [15:0] o_res_one;
    logic [15:0] o_res_two;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = yfbfr_pkg::CFG_DIRECTION;
    logic [15:0] i_cfg_data = 16'd0;

    int              mismatch_count;
    int              pending_words;
    int              cycle_count = 0;
    yfbfr_pkg::t_cfg cur_cfg;

    // 12 ns period: 6 ns low, 6 ns high.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    yfbfr_lifting_color_transform_core #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_comp_zero  (i_comp_zero),
        .i_comp_one   (i_comp_one),
        .i_comp_two   (i_comp_two),
        .o_res_strobe (o_res_strobe),
        .o_res_zero   (o_res_zero),
        .o_res_one    (o_res_one),
        .o_res_two    (o_res_two),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    yfbfr_pixel_checker #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_comp_zero  (i_comp_zero),
        .i_comp_one   (i_comp_one),
        .i_comp_two   (i_comp_two),
        .i_res_strobe (o_res_strobe),
        .i_res_zero   (o_res_zero),
        .i_res_one    (o_res_one),
        .i_res_two    (o_res_two),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_mismatches (mismatch_count),
        .o_pending    (pending_words)
    );

    // Watchdog: a hung handshake or a word that never comes back ends the run here.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Every task below is entered right after a rising edge and returns right after one.

    // Present one pixel word and hold it until the core takes it.
    // Leave start high so back-to-back words need no second assignment.
    task automatic send_pixel(input logic [15:0] c0, input logic [15:0] c1,
                              input logic [15:0] c2);
        start       <= 1'b1;
        i_comp_zero <= c0;
        i_comp_one  <= c1;
        i_comp_two  <= c2;
        do @(posedge i_clk); while (busy);
    endtask

    // Drop start and hold off until every predicted word has come back.
    task automatic drain_results();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_words != 0);
    endtask

    // Write all seven registers, one handshake each, valid held high across the burst.
    task automatic program_cfg(input yfbfr_pkg::t_cfg c);
        logic [15:0] vals [7];
        vals[yfbfr_pkg::CFG_DIRECTION]    = 16'(c.direction);
        vals[yfbfr_pkg::CFG_VARIANT]      = 16'(c.variant);
        vals[yfbfr_pkg::CFG_CHROMA_DEPTH] = 16'(c.chroma_depth);
        vals[yfbfr_pkg::CFG_FIRST_MIN]    = c.first_min;
        vals[yfbfr_pkg::CFG_FIRST_MAX]    = c.first_max;
        vals[yfbfr_pkg::CFG_OTHER_MIN]    = c.other_min;
        vals[yfbfr_pkg::CFG_OTHER_MAX]    = c.other_max;
        for (int idx = 0; idx < 7; idx++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= 3'(idx);
            i_cfg_data  <= vals[idx];
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
        cur_cfg = c;
    endtask

    // Settings change only with the pipe empty, so no word in flight sees a mix.
    task automatic new_settings(input yfbfr_pkg::t_cfg c);
        drain_results();
        program_cfg(c);
    endtask

    // Full clip windows and a 16-bit chroma offset: the raw lifting result shows through.
    function automatic yfbfr_pkg::t_cfg wide_cfg(input yfbfr_pkg::t_dir d,
                                                 input yfbfr_pkg::t_variant k);
        yfbfr_pkg::t_cfg c;
        c.direction    = d;
        c.variant      = k;
        c.chroma_depth = 5'd16;
        c.first_min    = 16'd0;
        c.first_max    = 16'hFFFF;
        c.other_min    = 16'd0;
        c.other_max    = 16'hFFFF;
        return c;
    endfunction

    // Pick one clip window: full range, a power-of-two range, anything, or min above max.
    function automatic void random_window(output logic [15:0] lo, output logic [15:0] hi);
        case ($urandom_range(0, 3))
            0: begin
                lo = 16'd0;
                hi = 16'hFFFF;
            end
            1: begin
                lo = 16'd0;
                hi = 16'((32'd1 << $urandom_range(8, 16)) - 1);
            end
            2: begin
                lo = 16'($urandom);
                hi = 16'($urandom);
            end
            default: begin
                hi = 16'($urandom_range(0, 32767));
                lo = hi + 16'($urandom_range(1, 32768));
            end
        endcase
    endfunction

    function automatic yfbfr_pkg::t_cfg random_settings();
        yfbfr_pkg::t_cfg c;
        c.direction = yfbfr_pkg::t_dir'($urandom_range(0, 1));
        c.variant   = yfbfr_pkg::t_variant'($urandom_range(0, 3));
        // Mostly real video depths; now and then a zero offset or one far past 16 bits.
        case ($urandom_range(0, 9))
            0:       c.chroma_depth = 5'd0;
            1:       c.chroma_depth = 5'($urandom_range(17, 31));
            2:       c.chroma_depth = 5'($urandom_range(1, 7));
            default: c.chroma_depth = 5'($urandom_range(8, 16));
        endcase
        random_window(c.first_min, c.first_max);
        random_window(c.other_min, c.other_max);
        return c;
    endfunction

    // One component: full random, confined to the chroma depth, an extreme, or near mid-range.
    function automatic logic [15:0] random_comp(input yfbfr_pkg::t_cfg c);
        int unsigned depth;
        logic [15:0] lim;
        depth = (c.chroma_depth == 5'd0) ? 1 : (c.chroma_depth > 5'd16) ? 16 : c.chroma_depth;
        lim   = 16'((32'd1 << depth) - 1);
        case ($urandom_range(0, 5))
            0, 1: return 16'($urandom);
            2, 3: return 16'($urandom) & lim;
            4: begin
                case ($urandom_range(0, 2))
                    0:       return 16'h0000;
                    1:       return lim;
                    default: return 16'hFFFF;
                endcase
            end
            default: return (lim >> 1) + 16'($urandom_range(0, 16)) - 16'd8;
        endcase
    endfunction

    initial begin
        yfbfr_pkg::t_cfg sc;
        bit              idle_ok;

        // Hold reset with every input at a known value.
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: every direction and variant with the extreme differences.
        for (int d = 0; d < 2; d++) begin
            for (int k = 0; k < 4; k++) begin
                new_settings(wide_cfg(yfbfr_pkg::t_dir'(d), yfbfr_pkg::t_variant'(k)));
                send_pixel(16'hFFFF, 16'h0000, 16'h0000);
                send_pixel(16'h0000, 16'hFFFF, 16'hFFFF);
            end
        end

        // Minimum above maximum on both windows: the maximum has to win.
        sc           = wide_cfg(yfbfr_pkg::DIR_FWD, yfbfr_pkg::VAR_V3);
        sc.first_min = 16'd900;
        sc.first_max = 16'd100;
        sc.other_min = 16'd60000;
        sc.other_max = 16'd5;
        new_settings(sc);
        send_pixel(16'h0000, 16'h0000, 16'h0000);
        send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);

        // Chroma depth zero: inverse runs with no chroma offset.
        sc              = wide_cfg(yfbfr_pkg::DIR_INV, yfbfr_pkg::VAR_V4);
        sc.chroma_depth = 5'd0;
        new_settings(sc);
        send_pixel(16'h8000, 16'h0000, 16'hFFFF);
        send_pixel(16'hFFFF, 16'hFFFF, 16'h0000);

        // Largest chroma depth: a huge offset that clipping must absorb.
        sc.chroma_depth = 5'd31;
        sc.variant      = yfbfr_pkg::VAR_V2;
        new_settings(sc);
        send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_pixel(16'h0000, 16'h1234, 16'hFEDC);

        // Random phases. Every fourth phase and the last three run without gaps.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            new_settings(random_settings());
            idle_ok = (ph < RANDOM_PHASES - 3) && (ph % 4 != 3);
            for (int n = 0; n < PHASE_WORDS; n++) begin
                if (ph == 5 && n == 12) begin
                    // Stall the sender mid-phase until the pipe is empty.
                    drain_results();
                end else if (idle_ok && $urandom_range(0, 4) == 0) begin
                    start <= 1'b0;
                    repeat ($urandom_range(1, 12)) @(posedge i_clk);
                end
                send_pixel(random_comp(cur_cfg), random_comp(cur_cfg), random_comp(cur_cfg));
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_words == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/yfbfr_pkg.sv
rtl/yfbfr_cfg.sv
rtl/yfbfr_lift.sv
rtl/yfbfr_clip.sv
rtl/yfbfr_lifting_color_transform_core.sv
rtl/yfbfr_chk.sv
verif/yfbfr_pixel_checker.sv
verif/tb_yfbfr_lifting_color_transform_core.sv
